// ----- src/color_vision_contrast_filter_core_assert.svh -----
// Assertion macros shared by the filter modules.
`ifndef COLOR_VISION_CONTRAST_FILTER_CORE_ASSERT_SVH
`define COLOR_VISION_CONTRAST_FILTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CVCF_ASSERT_IMP(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define CVCF_ASSERT_NXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- src/cvcf_pkg.sv -----
`default_nettype none

package cvcf_pkg;

  localparam int CVCF_CHANNEL_BITS   = 8;
  localparam int CVCF_COEF_FRAC_BITS = 10;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_PROTAN,
    MODE_DEUTAN,
    MODE_TRITAN
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  contrast;
  } ctrl_t;

  localparam int   CFG_DATA_BITS     = 2;
  localparam logic CFG_VISION_MODE   = 1'b0;
  localparam logic CFG_HIGH_CONTRAST = 1'b1;

  // Mix weights in thousandths.
  localparam int PROTAN_R_R = 567;
  localparam int PROTAN_R_G = 433;
  localparam int PROTAN_G_G = 558;
  localparam int PROTAN_G_R = 442;
  localparam int DEUTAN_R_R = 625;
  localparam int DEUTAN_R_G = 375;
  localparam int DEUTAN_G_G = 700;
  localparam int DEUTAN_G_R = 300;
  localparam int TRITAN_G_G = 950;
  localparam int TRITAN_G_B = 50;
  localparam int TRITAN_B_B = 433;
  localparam int TRITAN_B_G = 567;

  // Rounds a weight in thousandths to frac_bits fraction bits, halves up.
  function automatic int coef(input int milli, input int frac_bits);
    return (milli * (1 << frac_bits) + 500) / 1000;
  endfunction

endpackage

`default_nettype wire

// ----- src/color_vision_contrast_filter_core.sv -----
// Color vision filter: takes one RGB pixel per item and returns one adjusted pixel
// per item, at a sustained rate of one item per clock while the output is not
// stalled. The pipeline has three register stages, one each for the first channel
// mix, the second channel mix and the contrast curve; an accepted item passes
// through them in that order before it is offered at the output. A stage that holds
// no item accepts a new one even while the output waits, so bubbles close up under
// stall. The vision mode and high contrast registers are written through the plain
// write port and should only change while no item is in flight.
`default_nettype none
`include "color_vision_contrast_filter_core_assert.svh"

module color_vision_contrast_filter_core
  import cvcf_pkg::*;
#(
  parameter int CHANNEL_BITS   = CVCF_CHANNEL_BITS,
  parameter int COEF_FRAC_BITS = CVCF_COEF_FRAC_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic                     cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [CHANNEL_BITS-1:0]  red_in,
  input  wire logic [CHANNEL_BITS-1:0]  green_in,
  input  wire logic [CHANNEL_BITS-1:0]  blue_in,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [CHANNEL_BITS-1:0]       red_out,
  output logic [CHANNEL_BITS-1:0]       green_out,
  output logic [CHANNEL_BITS-1:0]       blue_out
);

  ctrl_t cfg;
  ctrl_t ctrl1;
  ctrl_t ctrl2;

  logic                    valid1;
  logic                    valid2;
  logic                    ready1;
  logic                    ready2;
  logic                    ready3;
  logic [CHANNEL_BITS-1:0] red1;
  logic [CHANNEL_BITS-1:0] green1;
  logic [CHANNEL_BITS-1:0] blue1;
  logic [CHANNEL_BITS-1:0] red2;
  logic [CHANNEL_BITS-1:0] green2;
  logic [CHANNEL_BITS-1:0] blue2;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_NONE;
      cfg.contrast <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_VISION_MODE:   cfg.mode     <= mode_t'(cfg_data[1:0]);
        CFG_HIGH_CONTRAST: cfg.contrast <= cfg_data[0];
      endcase
    end
  end

  assign ready3   = !out_valid || !out_stall;
  assign ready2   = !valid2 || ready3;
  assign ready1   = !valid1 || ready2;
  assign in_stall = !ready1;

  cvcf_mix_stage #(
    .CHANNEL_BITS  (CHANNEL_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .STEP          (0)
  ) u_mix_first (
    .clk     (clk),
    .rst     (rst),
    .load    (ready1),
    .valid_in(in_valid),
    .ctrl_in (cfg),
    .red_in  (red_in),
    .green_in(green_in),
    .blue_in (blue_in),
    .valid   (valid1),
    .ctrl    (ctrl1),
    .red     (red1),
    .green   (green1),
    .blue    (blue1)
  );

  cvcf_mix_stage #(
    .CHANNEL_BITS  (CHANNEL_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .STEP          (1)
  ) u_mix_second (
    .clk     (clk),
    .rst     (rst),
    .load    (ready2),
    .valid_in(valid1),
    .ctrl_in (ctrl1),
    .red_in  (red1),
    .green_in(green1),
    .blue_in (blue1),
    .valid   (valid2),
    .ctrl    (ctrl2),
    .red     (red2),
    .green   (green2),
    .blue    (blue2)
  );

  cvcf_curve_stage #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_curve (
    .clk     (clk),
    .rst     (rst),
    .load    (ready3),
    .valid_in(valid2),
    .ctrl_in (ctrl2),
    .red_in  (red2),
    .green_in(green2),
    .blue_in (blue2),
    .valid   (out_valid),
    .red     (red_out),
    .green   (green_out),
    .blue    (blue_out)
  );

  `CVCF_ASSERT_IMP(a_bubble_accepts, clk, rst, !valid1 || !valid2 || !out_valid, !in_stall, "Input stalled with an empty stage.")
  `CVCF_ASSERT_NXT(a_stage_holds, clk, rst, valid2 && !ready2, valid2, "Item lost in a stalled stage.")

endmodule

`default_nettype wire

// ----- src/cvcf_mix_stage.sv -----
`default_nettype none
`include "color_vision_contrast_filter_core_assert.svh"

module cvcf_mix_stage
  import cvcf_pkg::*;
#(
  parameter int CHANNEL_BITS   = CVCF_CHANNEL_BITS,
  parameter int COEF_FRAC_BITS = CVCF_COEF_FRAC_BITS,
  parameter int STEP           = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire logic                    valid_in,
  input  wire ctrl_t                   ctrl_in,
  input  wire logic [CHANNEL_BITS-1:0] red_in,
  input  wire logic [CHANNEL_BITS-1:0] green_in,
  input  wire logic [CHANNEL_BITS-1:0] blue_in,
  output logic                         valid,
  output ctrl_t                        ctrl,
  output logic [CHANNEL_BITS-1:0]      red,
  output logic [CHANNEL_BITS-1:0]      green,
  output logic [CHANNEL_BITS-1:0]      blue
);

  localparam int W  = CHANNEL_BITS;
  localparam int CW = COEF_FRAC_BITS + 1;
  localparam int PW = W + CW;
  localparam int SW = PW + 1;

  localparam logic [CW-1:0] CA_P = CW'(coef(STEP == 0 ? PROTAN_R_R : PROTAN_G_G,
                                            COEF_FRAC_BITS));
  localparam logic [CW-1:0] CB_P = CW'(coef(STEP == 0 ? PROTAN_R_G : PROTAN_G_R,
                                            COEF_FRAC_BITS));
  localparam logic [CW-1:0] CA_D = CW'(coef(STEP == 0 ? DEUTAN_R_R : DEUTAN_G_G,
                                            COEF_FRAC_BITS));
  localparam logic [CW-1:0] CB_D = CW'(coef(STEP == 0 ? DEUTAN_R_G : DEUTAN_G_R,
                                            COEF_FRAC_BITS));
  localparam logic [CW-1:0] CA_T = CW'(coef(STEP == 0 ? TRITAN_G_G : TRITAN_B_B,
                                            COEF_FRAC_BITS));
  localparam logic [CW-1:0] CB_T = CW'(coef(STEP == 0 ? TRITAN_G_B : TRITAN_B_G,
                                            COEF_FRAC_BITS));
  localparam logic [SW-1:0] HALF = SW'(1) << (COEF_FRAC_BITS - 1);

  logic [W-1:0]  op_a;
  logic [W-1:0]  op_b;
  logic [CW-1:0] coef_a;
  logic [CW-1:0] coef_b;
  logic [PW-1:0] prod_a;
  logic [PW-1:0] prod_b;
  logic [SW-1:0] sum;
  logic [W+1:0]  scaled;
  logic [W-1:0]  mixed;
  logic [W-1:0]  red_next;
  logic [W-1:0]  green_next;
  logic [W-1:0]  blue_next;

  always_comb begin
    op_a   = red_in;
    op_b   = green_in;
    coef_a = CA_P;
    coef_b = CB_P;
    if (STEP == 0) begin
      unique case (ctrl_in.mode)
        MODE_NONE: begin
          op_a = red_in;
          op_b = green_in;
        end
        MODE_PROTAN: begin
          op_a   = red_in;
          op_b   = green_in;
          coef_a = CA_P;
          coef_b = CB_P;
        end
        MODE_DEUTAN: begin
          op_a   = red_in;
          op_b   = green_in;
          coef_a = CA_D;
          coef_b = CB_D;
        end
        MODE_TRITAN: begin
          op_a   = green_in;
          op_b   = blue_in;
          coef_a = CA_T;
          coef_b = CB_T;
        end
      endcase
    end else begin
      unique case (ctrl_in.mode)
        MODE_NONE: begin
          op_a = green_in;
          op_b = red_in;
        end
        MODE_PROTAN: begin
          op_a   = green_in;
          op_b   = red_in;
          coef_a = CA_P;
          coef_b = CB_P;
        end
        MODE_DEUTAN: begin
          op_a   = green_in;
          op_b   = red_in;
          coef_a = CA_D;
          coef_b = CB_D;
        end
        MODE_TRITAN: begin
          op_a   = blue_in;
          op_b   = green_in;
          coef_a = CA_T;
          coef_b = CB_T;
        end
      endcase
    end
  end

  assign prod_a = PW'(op_a) * PW'(coef_a);
  assign prod_b = PW'(op_b) * PW'(coef_b);
  assign sum    = SW'(prod_a) + SW'(prod_b) + HALF;
  assign scaled = sum[SW-1:COEF_FRAC_BITS];
  assign mixed  = (|scaled[W+1:W]) ? {W{1'b1}} : scaled[W-1:0];

  always_comb begin
    red_next   = red_in;
    green_next = green_in;
    blue_next  = blue_in;
    unique case (ctrl_in.mode)
      MODE_NONE: begin
        red_next = red_in;
      end
      MODE_PROTAN, MODE_DEUTAN: begin
        if (STEP == 0) begin
          red_next = mixed;
        end else begin
          green_next = mixed;
        end
      end
      MODE_TRITAN: begin
        if (STEP == 0) begin
          green_next = mixed;
        end else begin
          blue_next = mixed;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctrl  <= ctrl_in;
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  `CVCF_ASSERT_NXT(a_mix_bypass, clk, rst, load && valid_in && ctrl_in.mode == MODE_NONE, red == $past(red_in) && green == $past(green_in) && blue == $past(blue_in), "Pixel changed with no vision mode.")

endmodule

`default_nettype wire

// ----- src/cvcf_curve_stage.sv -----
`default_nettype none
`include "color_vision_contrast_filter_core_assert.svh"

module cvcf_curve_stage
  import cvcf_pkg::*;
#(
  parameter int CHANNEL_BITS = CVCF_CHANNEL_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire logic                    valid_in,
  input  wire ctrl_t                   ctrl_in,
  input  wire logic [CHANNEL_BITS-1:0] red_in,
  input  wire logic [CHANNEL_BITS-1:0] green_in,
  input  wire logic [CHANNEL_BITS-1:0] blue_in,
  output logic                         valid,
  output logic [CHANNEL_BITS-1:0]      red,
  output logic [CHANNEL_BITS-1:0]      green,
  output logic [CHANNEL_BITS-1:0]      blue
);

  localparam int W = CHANNEL_BITS;
  localparam logic [W-1:0] MAXV = {W{1'b1}};

  logic apply;

  function automatic logic [W-1:0] curve(input logic [W-1:0] x);
    logic [W:0]   twice;
    logic [W:0]   plus_one;
    logic [W+2:0] six;
    logic [W+2:0] shifted;
    logic [W:0]   high;
    twice    = {x, 1'b0};
    plus_one = {1'b0, x} + (W+1)'(1);
    six      = ({3'b000, x} << 2) + ({3'b000, x} << 1);
    shifted  = six - (W+3)'(MAXV) + (W+3)'(2);
    high     = shifted[W+2:2];
    if (twice < {1'b0, MAXV}) begin
      return plus_one[W:1];
    end else if (high[W]) begin
      return MAXV;
    end else begin
      return high[W-1:0];
    end
  endfunction

  assign apply = ctrl_in.contrast && (ctrl_in.mode != MODE_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red   <= apply ? curve(red_in)   : red_in;
      green <= apply ? curve(green_in) : green_in;
      blue  <= apply ? curve(blue_in)  : blue_in;
    end
  end

  `CVCF_ASSERT_NXT(a_curve_bypass, clk, rst, load && valid_in && !ctrl_in.contrast, red == $past(red_in) && green == $past(green_in) && blue == $past(blue_in), "Curve applied with high contrast off.")

endmodule

`default_nettype wire
